// ----- hw/rtl/crpp_pkg.sv -----
// ----------------------------------------------------------------------------
// crpp_pkg
// shared widths, register indexes and constants of the circle ring painter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crpp_pkg;

  localparam int unsigned MaxDim = 4096;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned CentreW = 14;
  localparam int unsigned LenW    = 13;
  localparam int unsigned ColourW = 24;
  localparam int unsigned CfgIdxW = 3;

  // difference of pixel and centre, signed
  localparam int unsigned DiffW = CentreW + 1;
  // square of one difference
  localparam int unsigned SqW   = 2 * DiffW - 2;
  // four times the squared distance, and every squared bound
  localparam int unsigned DistW = SqW + 3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [ColourW-1:0] colour_t;
  typedef logic [DistW-1:0]   dist_t;

  localparam cfg_idx_t RegCenterX      = 3'd0;
  localparam cfg_idx_t RegCenterY      = 3'd1;
  localparam cfg_idx_t RegCircleRadius = 3'd2;
  localparam cfg_idx_t RegRingThick    = 3'd3;
  localparam cfg_idx_t RegFillEnable   = 3'd4;
  localparam cfg_idx_t RegOutlineRgb   = 3'd5;
  localparam cfg_idx_t RegInteriorRgb  = 3'd6;

endpackage

// ----- hw/rtl/circle_ring_pixel_painter.sv -----
// ----------------------------------------------------------------------------
// circle_ring_pixel_painter
// Pipeline: a pixel request taken at a start edge passes the registers
// v1_q, v2_q, v3_q and valid_q to its result strobe. Throughput: one pixel
// per cycle, busy stays low and the receiver cannot stall. Reset clears all
// settings to zero and drops any pixel still in the pipeline. Squared bounds
// follow a settings write through the setting, doubled and squared registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_ring_pixel_painter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  crpp_pkg::cfg_idx_t        cfg_idx_i,
  input  logic [crpp_pkg::ColourW-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [crpp_pkg::CoordW-1:0] pixel_x_i,
  input  logic [crpp_pkg::CoordW-1:0] pixel_y_i,
  input  logic [7:0]                in_red_i,
  input  logic [7:0]                in_green_i,
  input  logic [7:0]                in_blue_i,
  output logic                      result_valid_o,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic                      bad_setting_o
);
  import crpp_pkg::*;

  // settings
  logic signed [CentreW-1:0] center_x_q, center_y_q;
  logic [LenW-1:0]           radius_q, thick_q;
  logic                      fill_q;
  colour_t                   outline_q, interior_q;

  // derived bounds, doubled units
  logic [LenW:0]   rad2_q, inner2_q;
  logic [LenW+1:0] outer2_q;
  dist_t           rad_sq_q, inner_sq_q, outer_sq_q;
  logic [LenW:0]   rad2_d, inner2_d;
  logic [LenW+1:0] outer2_d;

  // pipeline
  logic                    v1_q, v2_q, v3_q, valid_q;
  logic signed [DiffW-1:0] dx1_q, dy1_q;
  logic [SqW-1:0]          sqx2_q, sqy2_q;
  dist_t                   dist3_q;
  colour_t                 rgb1_q, rgb2_q, rgb3_q, rgb_q;
  logic                    bad1_q, bad2_q, bad3_q, bad_q;
  logic                    skip1_q, skip2_q, skip3_q;

  logic                    accept;
  logic signed [DiffW-1:0] dx_d, dy_d;
  logic                    bad_d, oor_d;
  logic signed [2*DiffW-1:0] prodx, prody;
  dist_t                   dist_d;
  logic                    in_disc, on_ring;
  colour_t                 rgb_d;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // settings writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      thick_q    <= '0;
      fill_q     <= 1'b0;
      outline_q  <= '0;
      interior_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCenterX:      center_x_q <= cfg_wdata_i[CentreW-1:0];
        RegCenterY:      center_y_q <= cfg_wdata_i[CentreW-1:0];
        RegCircleRadius: radius_q   <= cfg_wdata_i[LenW-1:0];
        RegRingThick:    thick_q    <= cfg_wdata_i[LenW-1:0];
        RegFillEnable:   fill_q     <= cfg_wdata_i[0];
        RegOutlineRgb:   outline_q  <= cfg_wdata_i;
        RegInteriorRgb:  interior_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // bounds, inner edge clamped at zero
  always_comb begin
    rad2_d   = {radius_q, 1'b0};
    inner2_d = (rad2_d > {1'b0, thick_q}) ? (rad2_d - {1'b0, thick_q}) : '0;
    outer2_d = {1'b0, rad2_d} + {2'b00, thick_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad2_q     <= '0;
      inner2_q   <= '0;
      outer2_q   <= '0;
      rad_sq_q   <= '0;
      inner_sq_q <= '0;
      outer_sq_q <= '0;
    end else begin
      rad2_q     <= rad2_d;
      inner2_q   <= inner2_d;
      outer2_q   <= outer2_d;
      rad_sq_q   <= dist_t'(rad2_q) * dist_t'(rad2_q);
      inner_sq_q <= dist_t'(inner2_q) * dist_t'(inner2_q);
      outer_sq_q <= dist_t'(outer2_q) * dist_t'(outer2_q);
    end
  end

  // stage 1: differences and request flags
  always_comb begin
    dx_d  = $signed({3'b000, pixel_x_i}) - $signed({center_x_q[CentreW-1], center_x_q});
    dy_d  = $signed({3'b000, pixel_y_i}) - $signed({center_y_q[CentreW-1], center_y_q});
    bad_d = (radius_q == '0) || (thick_q == '0);
    oor_d = (int'(pixel_x_i) >= MaxDim) || (int'(pixel_y_i) >= MaxDim);
  end

  // stage 2: squares
  assign prodx = dx1_q * dx1_q;
  assign prody = dy1_q * dy1_q;

  // stage 4: ring and disc tests, outline wins
  always_comb begin
    in_disc = fill_q && (dist3_q <= rad_sq_q);
    on_ring = (dist3_q >= inner_sq_q) && (dist3_q <= outer_sq_q);
    rgb_d   = rgb3_q;
    if (!skip3_q) begin
      if (in_disc) begin
        rgb_d = interior_q;
      end
      if (on_ring) begin
        rgb_d = outline_q;
      end
    end
  end

  assign dist_d = {DistW'({1'b0, sqx2_q} + {1'b0, sqy2_q})} << 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q   <= dx_d;
    dy1_q   <= dy_d;
    rgb1_q  <= {in_red_i, in_green_i, in_blue_i};
    bad1_q  <= bad_d;
    skip1_q <= bad_d | oor_d;

    sqx2_q  <= prodx[SqW-1:0];
    sqy2_q  <= prody[SqW-1:0];
    rgb2_q  <= rgb1_q;
    bad2_q  <= bad1_q;
    skip2_q <= skip1_q;

    dist3_q <= dist_d;
    rgb3_q  <= rgb2_q;
    bad3_q  <= bad2_q;
    skip3_q <= skip2_q;

    rgb_q   <= rgb_d;
    bad_q   <= bad3_q;
  end

  assign result_valid_o = valid_q;
  assign out_red_o      = rgb_q[23:16];
  assign out_green_o    = rgb_q[15:8];
  assign out_blue_o     = rgb_q[7:0];
  assign bad_setting_o  = bad_q;

  // every request gives a result once it has passed the pipeline
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 result_valid_o)
    else $error("request lost in pipeline");

  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 4))
    else $error("result without request");

  a_bad_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && bad_setting_o |->
      (out_red_o == $past(in_red_i, 4)) && (out_green_o == $past(in_green_i, 4)) &&
      (out_blue_o == $past(in_blue_i, 4)))
    else $error("pixel changed under bad setting");

  a_colour_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (out_blue_o != $past(in_blue_i, 4)) |->
      (out_blue_o == outline_q[7:0]) || (fill_q && (out_blue_o == interior_q[7:0])))
    else $error("painted colour from no source");

endmodule
